/* hw/rtl/drr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_pkg
// Shared codes and controller/datapath interface types for the delta
// regression ring.
// ----------------------------------------------------------------------------
package drr_pkg;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] CFG_VECTOR_LENGTH     = 2'd0;
  localparam logic [1:0] CFG_WINDOW_HALF_WIDTH = 2'd1;

  localparam logic [6:0] VLEN_RESET = 7'd13;
  localparam logic [3:0] WIN_RESET  = 4'd2;

  typedef struct packed {
    logic accept;
    logic elem_init;
    logic cap_static;
    logic nb_read;
    logic acc;
    logic div_init;
    logic div_step;
    logic out_load;
  } drr_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic t_last;
    logic div_done;
    logic n_last;
    logic out_free;
  } drr_stat_t;

endpackage

/* hw/rtl/drr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_ctrl
// Sequencer: accepts words, then walks each element of an emitted frame
// through center read, neighbor reads, accumulation, division and output.
// ----------------------------------------------------------------------------
module drr_ctrl import drr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  drr_stat_t stat_i,
  output drr_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CEN  = 8'b0000_0010,
    ST_CAP  = 8'b0000_0100,
    ST_RD   = 8'b0000_1000,
    ST_ACC  = 8'b0001_0000,
    ST_DVI  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } drr_state_e;

  drr_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.emit_req) state_d = ST_CEN;
        end
      end
      ST_CEN: begin
        cmd_o.elem_init = 1'b1;
        state_d         = ST_CAP;
      end
      ST_CAP: begin
        cmd_o.cap_static = 1'b1;
        state_d          = ST_RD;
      end
      ST_RD: begin
        cmd_o.nb_read = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = stat_i.t_last ? ST_DVI : ST_RD;
      end
      ST_DVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = stat_i.n_last ? ST_IDLE : ST_CEN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/drr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_datapath
// Frame ring memory, slot valid flags, neighbor tracking, regression
// accumulator, restoring divider and output register.
// ----------------------------------------------------------------------------
module drr_datapath import drr_pkg::*; #(
  parameter  int MAX_VEC = 64,
  parameter  int MAX_WIN = 8,
  localparam int LEN_W   = $clog2(MAX_VEC + 1),
  localparam int WIN_W   = $clog2(MAX_WIN + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drr_cmd_t          cmd_i,
  output drr_stat_t         stat_o,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  input  logic [31:0]       coef_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic [WIN_W-1:0]  win_i,
  input  logic              cfg_clear_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [31:0]       static_out_o,
  output logic [31:0]       delta_out_o,
  output logic [5:0]        elem_index_o,
  output logic              frame_last_o
);

  localparam int NSLOT   = 2 * MAX_WIN + 1;
  localparam int SLOT_W  = $clog2(NSLOT);
  localparam int IDX_W   = (MAX_VEC > 1) ? $clog2(MAX_VEC) : 1;
  localparam int DEPTH   = NSLOT * MAX_VEC;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DEN_MAX = MAX_WIN * (MAX_WIN + 1) * (2 * MAX_WIN + 1) / 3;
  localparam int DEN_W   = $clog2(DEN_MAX + 1);
  localparam int PROD_W  = 34 + WIN_W;
  localparam int SUM_W   = PROD_W + $clog2(MAX_WIN + 1);
  localparam int CNT_W   = $clog2(SUM_W);

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [IDX_W-1:0] idx);
    ring_addr = ADDR_W'(slot) * ADDR_W'(MAX_VEC) + ADDR_W'(idx);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] last);
    slot_inc = (s == last) ? '0 : s + SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] last);
    slot_dec = (s == '0) ? last : s - SLOT_W'(1);
  endfunction

  logic [31:0]              mem [DEPTH];
  logic [31:0]              rd_a_q, rd_b_q;
  logic [NSLOT-1:0]         valid_q;
  logic [SLOT_W-1:0]        store_q, cur_q, lv_q, rv_q, pl_q, pr_q;
  logic [IDX_W-1:0]         elem_q, n_q;
  logic [WIN_W-1:0]         t_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [DEN_W-1:0]         den_q, rem_q;
  logic [SUM_W-1:0]         quo_q;
  logic                     neg_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [31:0]              static_q;
  logic                     out_valid_q;

  logic [SLOT_W-1:0]        w_s, last_slot, cur_calc, lv_new, rv_new;
  logic                     elem_last;
  logic [ADDR_W-1:0]        addr_a, addr_b, addr_w;
  logic signed [32:0]       diff;
  logic signed [PROD_W-1:0] prod;
  logic [2*WIN_W-1:0]       tt;
  logic [DEN_W:0]           sh, sh_sub;
  logic                     ge;
  logic [SUM_W-1:0]         sum_mag;
  logic [31:0]              delta_sat;

  always_comb begin
    w_s       = SLOT_W'(win_i);
    last_slot = SLOT_W'({win_i, 1'b0});
    cur_calc  = (store_q >= w_s) ? store_q - w_s : store_q + w_s + SLOT_W'(1);
    elem_last = (LEN_W'(elem_q) == len_i - LEN_W'(1));
    lv_new    = valid_q[pl_q] ? pl_q : lv_q;
    rv_new    = valid_q[pr_q] ? pr_q : rv_q;
    addr_a    = cmd_i.elem_init ? ring_addr(cur_q, n_q) : ring_addr(rv_new, n_q);
    addr_b    = ring_addr(lv_new, n_q);
    addr_w    = ring_addr(store_q, elem_q);
    diff      = $signed({rd_a_q[31], rd_a_q}) - $signed({rd_b_q[31], rd_b_q});
    prod      = PROD_W'(diff) * PROD_W'($signed({1'b0, t_q}));
    tt        = t_q * t_q;
    sh        = {rem_q, quo_q[SUM_W-1]};
    sh_sub    = sh - {1'b0, den_q};
    ge        = (sh >= {1'b0, den_q});
    sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    if (neg_q) begin
      delta_sat = (quo_q > SUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : -quo_q[31:0];
    end else begin
      delta_sat = (quo_q > SUM_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_q[31:0];
    end
  end

  always_comb begin
    stat_o.emit_req = in_valid_i && valid_q[cur_calc] &&
                      (((in_cmd_i == CMD_PUSH) && elem_last) || (in_cmd_i == CMD_FLUSH));
    stat_o.t_last   = (t_q == win_i);
    stat_o.div_done = (cnt_q == CNT_W'(SUM_W - 1));
    stat_o.n_last   = (LEN_W'(n_q) == len_i - LEN_W'(1));
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      store_q     <= '0;
      elem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_clear_i) begin
        valid_q <= '0;
        store_q <= '0;
        elem_q  <= '0;
      end else if (cmd_i.accept) begin
        case (in_cmd_i)
          CMD_PUSH: begin
            if (elem_last) begin
              elem_q           <= '0;
              valid_q[store_q] <= 1'b1;
              store_q          <= slot_inc(store_q, last_slot);
            end else begin
              elem_q <= elem_q + IDX_W'(1);
            end
          end
          CMD_FLUSH: begin
            elem_q           <= '0;
            valid_q[store_q] <= 1'b0;
            store_q          <= slot_inc(store_q, last_slot);
          end
          CMD_CLEAR: begin
            valid_q <= '0;
            store_q <= '0;
            elem_q  <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_cmd_i == CMD_PUSH)) begin
      mem[addr_w] <= coef_i;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
    if (cmd_i.accept) begin
      cur_q <= cur_calc;
      n_q   <= '0;
    end
    if (cmd_i.elem_init) begin
      lv_q  <= cur_q;
      rv_q  <= cur_q;
      pl_q  <= slot_dec(cur_q, last_slot);
      pr_q  <= slot_inc(cur_q, last_slot);
      t_q   <= WIN_W'(1);
      sum_q <= '0;
      den_q <= '0;
    end
    if (cmd_i.cap_static) begin
      static_q <= rd_a_q;
    end
    if (cmd_i.nb_read) begin
      lv_q <= lv_new;
      rv_q <= rv_new;
      pl_q <= slot_dec(pl_q, last_slot);
      pr_q <= slot_inc(pr_q, last_slot);
    end
    if (cmd_i.acc) begin
      sum_q <= sum_q + SUM_W'(prod);
      den_q <= den_q + DEN_W'({tt, 1'b0});
      t_q   <= t_q + WIN_W'(1);
    end
    if (cmd_i.div_init) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= sum_mag;
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? sh_sub[DEN_W-1:0] : sh[DEN_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.out_load) begin
      static_out_o <= static_q;
      delta_out_o  <= delta_sat;
      elem_index_o <= 6'(n_q);
      frame_last_o <= stat_o.n_last;
      n_q          <= n_q + IDX_W'(1);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/delta_regression_ring_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_regression_ring_unit
// Streaming delta (regression) coefficients over a ring of frame vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (cmd_i, coef_i) move on in_valid_i / in_stall_o. A push
//   stores one Q16.16 coefficient; the push that completes a frame, and a
//   flush, emit the frame W slots behind when its slot is valid. Clear
//   empties the ring. Output words (static, delta, index, last flag) move
//   on out_valid_o / out_stall_i, one per element of the emitted frame.
//   Configuration writes (cfg_index_i, cfg_data_i) are taken every cycle; those
//   to length or window also clear the ring; issue them only while the block
//   is idle.
// Sequence:
//   A word that emits nothing leaves the input open. An emitting word holds
//   it while each element gets a center read and static capture, a read and
//   accumulate per neighbor pair on the two-port ring memory, a divider setup,
//   SUM_W (42 by default) steps of the bit-serial divider and an output load.
//   A stalled output word holds and the sequencer waits in front of it;
//   the input is taken again while the final word of a frame still waits.
// Reset clears the slot flags, pointers and output valid; ring contents
//   stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module delta_regression_ring_unit import drr_pkg::*; #(
  parameter int MAX_VEC = 64,
  parameter int MAX_WIN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] coef_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] static_out_o,
  output logic [31:0] delta_out_o,
  output logic [5:0]  elem_index_o,
  output logic        frame_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int LEN_W = $clog2(MAX_VEC + 1);
  localparam int WIN_W = $clog2(MAX_WIN + 1);

  logic [6:0]       vlen_q;
  logic [3:0]       win_q;
  logic [LEN_W-1:0] len_eff;
  logic [WIN_W-1:0] win_eff;
  logic             cfg_write, cfg_clear;
  drr_cmd_t         cmd;
  drr_stat_t        stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_write && ((cfg_index_i == CFG_VECTOR_LENGTH) ||
                                     (cfg_index_i == CFG_WINDOW_HALF_WIDTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= VLEN_RESET;
      win_q  <= WIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_VECTOR_LENGTH:     vlen_q <= cfg_data_i[6:0];
        CFG_WINDOW_HALF_WIDTH: win_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vlen_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(vlen_q) > MAX_VEC) begin
      len_eff = LEN_W'(MAX_VEC);
    end else begin
      len_eff = LEN_W'(vlen_q);
    end
    if (win_q == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(win_q) > MAX_WIN) begin
      win_eff = WIN_W'(MAX_WIN);
    end else begin
      win_eff = WIN_W'(win_q);
    end
  end

  drr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  drr_datapath #(
    .MAX_VEC (MAX_VEC),
    .MAX_WIN (MAX_WIN)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_valid_i   (in_valid_i),
    .in_cmd_i     (cmd_i),
    .coef_i       (coef_i),
    .len_i        (len_eff),
    .win_i        (win_eff),
    .cfg_clear_i  (cfg_clear),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .static_out_o (static_out_o),
    .delta_out_o  (delta_out_o),
    .elem_index_o (elem_index_o),
    .frame_last_o (frame_last_o)
  );

`ifndef SYNTHESIS
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> elem_index_o == 6'(len_eff - LEN_W'(1)))
    else $error("frame_last on wrong element index");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word produced while input was open");

  a_accept_no_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !cmd.out_load && !cmd.div_step && !cmd.acc)
    else $error("input accepted during frame emission");
`endif

endmodule
